FILE: rtl/sapd_pkg.sv
package sapd_pkg;

  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;
  localparam int CHAR_W = 8;
  localparam int RANK_W = 8;
  localparam int KEY_W  = RANK_W + 1;
  localparam int CNT_W  = 6;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INIT,
    OP_PREP,
    OP_SHIFT,
    OP_KEY,
    OP_COUNT,
    OP_RANK,
    OP_SCAN,
    OP_ROT,
    OP_FILL,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  wpos;
    logic [CHAR_W-1:0] wdata;
    logic [IDX_W-1:0]  last_idx;
    logic              cyc;
  } ctl_t;

  typedef struct packed {
    logic [KEY_W-1:0]  sh;
    logic [RANK_W-1:0] kr;
    logic [KEY_W-1:0]  ks;
    logic [IDX_W-1:0]  tag;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] ov;
    logic [IDX_W-1:0]  slot;
  } link_t;

endpackage

FILE: rtl/sapd_cell.sv
module sapd_cell (
  input  logic                        clk,
  input  logic [sapd_pkg::IDX_W-1:0]  pos,
  input  sapd_pkg::ctl_t              ctl,
  input  sapd_pkg::link_t             right,
  input  sapd_pkg::link_t             head,
  output sapd_pkg::link_t             link
);
  import sapd_pkg::*;

  logic [CHAR_W-1:0] ch;
  logic [RANK_W-1:0] rk;
  logic [KEY_W-1:0]  sh;
  logic [RANK_W-1:0] kr;
  logic [KEY_W-1:0]  ks;
  logic [IDX_W-1:0]  tag;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  slot;
  logic [CHAR_W-1:0] ov;
  logic              is_end;
  logic              lt;
  link_t             src;

  assign is_end = (pos == ctl.last_idx);
  assign src    = is_end ? head : right;
  assign lt     = (kr < rk) || ((kr == rk) && (ks < sh));

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (pos == ctl.wpos) begin
          ch <= ctl.wdata;
        end
      end
      OP_INIT: begin
        rk <= ch;
      end
      OP_PREP: begin
        sh <= {1'b0, rk} + KEY_W'(1);
      end
      OP_SHIFT: begin
        if (is_end) begin
          sh <= ctl.cyc ? head.sh : '0;
        end else begin
          sh <= right.sh;
        end
      end
      OP_KEY: begin
        kr  <= rk;
        ks  <= sh;
        tag <= pos;
        cnt <= '0;
      end
      OP_COUNT: begin
        if (lt) begin
          cnt <= cnt + CNT_W'(1);
        end
        kr  <= src.kr;
        ks  <= src.ks;
        tag <= src.tag;
      end
      OP_RANK: begin
        rk <= RANK_W'(cnt);
      end
      OP_SCAN: begin
        if (kr == RANK_W'(pos)) begin
          slot <= tag;
        end
        kr  <= src.kr;
        tag <= src.tag;
      end
      OP_ROT: begin
        ch <= src.ch;
      end
      OP_FILL: begin
        ov <= ctl.cyc ? ch : CHAR_W'(slot);
      end
      OP_OUT: begin
        ov <= right.ov;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    link.sh   = sh;
    link.kr   = kr;
    link.ks   = ks;
    link.tag  = tag;
    link.ch   = ch;
    link.ov   = ov;
    link.slot = slot;
  end

endmodule

FILE: rtl/sapd_ctrl.sv
module sapd_ctrl #(
  parameter int MAX_LEN = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sapd_pkg::CHAR_W-1:0] s_tdata,
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        m_tlast,
  output logic                        m_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic [sapd_pkg::IDX_W-1:0]  head_slot,
  output sapd_pkg::ctl_t              ctl
);
  import sapd_pkg::*;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b000000000001,
    S_INIT  = 12'b000000000010,
    S_PREP  = 12'b000000000100,
    S_SHIFT = 12'b000000001000,
    S_KEY   = 12'b000000010000,
    S_COUNT = 12'b000000100000,
    S_RANK  = 12'b000001000000,
    S_SKEY  = 12'b000010000000,
    S_SCAN  = 12'b000100000000,
    S_ROT   = 12'b001000000000,
    S_FILL  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t           state, state_next;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic [LEN_W-1:0] t;
  logic [LEN_W:0]   t2;
  logic [LEN_W-1:0] n_m1;
  logic             dropped;
  logic             mode;
  logic             full;
  logic             in_acc;
  logic             out_acc;

  assign full      = (len == LEN_W'(MAX_LEN));
  assign n_m1      = len - LEN_W'(1);
  assign t2        = {t, 1'b0};
  assign s_tready  = (state == S_LOAD);
  assign m_tvalid  = (state == S_OUT);
  assign m_tlast   = (cnt == n_m1);
  assign m_tuser   = dropped;
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ctl.op       = OP_IDLE;
    ctl.wpos     = len[IDX_W-1:0];
    ctl.wdata    = s_tdata;
    ctl.last_idx = n_m1[IDX_W-1:0];
    ctl.cyc      = mode;
    case (state)
      S_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            ctl.op = OP_LOAD;
          end
          if (s_tlast) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        ctl.op     = OP_INIT;
        state_next = S_PREP;
      end
      S_PREP: begin
        ctl.op     = OP_PREP;
        cnt_next   = '0;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        ctl.op   = OP_SHIFT;
        cnt_next = cnt + LEN_W'(1);
        if (cnt == t - LEN_W'(1)) begin
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        ctl.op     = OP_KEY;
        cnt_next   = '0;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        ctl.op   = OP_COUNT;
        cnt_next = cnt + LEN_W'(1);
        if (cnt == n_m1) begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        ctl.op     = OP_RANK;
        state_next = (t2 >= {1'b0, len}) ? S_SKEY : S_PREP;
      end
      S_SKEY: begin
        ctl.op     = OP_KEY;
        cnt_next   = '0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.op   = OP_SCAN;
        cnt_next = cnt + LEN_W'(1);
        if (cnt == n_m1) begin
          cnt_next   = '0;
          state_next = mode ? S_ROT : S_FILL;
        end
      end
      S_ROT: begin
        if (cnt[IDX_W-1:0] == head_slot) begin
          state_next = S_FILL;
        end else begin
          ctl.op   = OP_ROT;
          cnt_next = cnt + LEN_W'(1);
        end
      end
      S_FILL: begin
        ctl.op     = OP_FILL;
        cnt_next   = '0;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          ctl.op   = OP_OUT;
          cnt_next = cnt + LEN_W'(1);
          if (cnt == n_m1) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      len     <= '0;
      dropped <= 1'b0;
      mode    <= 1'b0;
      cnt     <= '0;
      t       <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      if (in_acc) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          len <= len + LEN_W'(1);
        end
      end
      if (state == S_INIT) begin
        t <= LEN_W'(1);
      end else if (state == S_RANK) begin
        t <= t2[LEN_W-1:0];
      end
      if (out_acc && m_tlast) begin
        len     <= '0;
        dropped <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/suffix_array_prefix_doubling_top.sv
// channel | direction | handshake          | payload
// s       | in        | s_tvalid/s_tready  | s_tdata = char_in, s_tlast = last_char
// m       | out       | m_tvalid/m_tready  | m_tdata = value, m_tlast = last_out,
//         |           |                    | m_tuser = overflow
// cfg     | in        | cfg_valid/cfg_ready| cfg_data = mode
//
// characters load one per cycle while s_tready is high; results start after the doubling rounds
// each round runs prep, shift, key, count and rank steps over the cell row, about log2(n) rounds
// then a key step and a scan, a rotate in mode 1, a fill step, n items out
// no new item is taken until the last result of a run is taken
// synchronous reset clears length, overflow, mode and control state
module suffix_array_prefix_doubling_top #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_in
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // value
  output logic       m_tlast,
  output logic       m_tuser,   // overflow
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import sapd_pkg::*;

  ctl_t  ctl;
  link_t links [MAX_LEN];

  sapd_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .head_slot(links[0].slot),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    link_t right;
    if (i == MAX_LEN - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = links[i+1];
    end
    sapd_cell u_cell (
      .clk  (clk),
      .pos  (IDX_W'(i)),
      .ctl  (ctl),
      .right(right),
      .head (links[0]),
      .link (links[i])
    );
  end

  assign m_tdata = links[0].ov;

endmodule

FILE: rtl/sapd_checker.sv
module sapd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input and output sides open together");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not back to loading after last result");

  a_last_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still open after last character");

  a_flag_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
    else $error("overflow flag changed within a run");

endmodule

bind suffix_array_prefix_doubling_top sapd_checker u_sapd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);
